// ----- hw/rtl/eops_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eops_pkg
// Shared types, codes and the fixed frame script of the encoder OTP
// programming sequencer.
// ---------------------------------------------------------------------------
package eops_pkg;

  // Number of frames in the script and the poll restart point
  localparam int unsigned NumFrames = 44;
  localparam logic [5:0]  POLL_STEP = 6'd22;
  localparam logic [5:0]  LAST_STEP = 6'(NumFrames - 1);

  // Configuration register indexes
  localparam logic [2:0] REG_DIRECTION   = 3'd0;
  localparam logic [2:0] REG_OUTPUT_MODE = 3'd1;
  localparam logic [2:0] REG_DAEC_ENABLE = 3'd2;
  localparam logic [2:0] REG_ABI_RES     = 3'd3;
  localparam logic [2:0] REG_POLE_PAIRS  = 3'd4;
  localparam logic [2:0] REG_HYSTERESIS  = 3'd5;

  // Error kinds kept across a group
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_WRITE  = 2'd1;
  localparam logic [1:0] ERR_READ   = 2'd2;
  localparam logic [1:0] ERR_VERIFY = 2'd3;

  // Status codes on the result channel
  localparam logic [2:0] STAT_RUNNING = 3'd0;
  localparam logic [2:0] STAT_SUCCESS = 3'd1;

  // Output mode codes
  localparam logic [1:0] OMODE_UVW_ABI = 2'd0;
  localparam logic [1:0] OMODE_UVW_PWM = 2'd1;

  // Frame argument: 0..3 select a settings/zero-position word, else literal
  localparam logic [2:0] ARG_LIT = 3'd4;

  // Poll done value
  localparam logic [13:0] PROG_DONE = 14'h0001;

  typedef enum logic [2:0] {
    FR_CMD    = 3'd0,
    FR_WDATA  = 3'd1,
    FR_RANGLE = 3'd2,
    FR_RVER   = 3'd3,
    FR_RPOLL  = 3'd4
  } frame_kind_t;

  typedef struct packed {
    logic [15:0] word;
    frame_kind_t kind;
    logic [2:0]  arg;
    logic        last;
  } frame_t;

  typedef struct packed {
    logic       direction;
    logic [1:0] output_mode;
    logic       daec_enable;
    logic [3:0] abi_res_code;
    logic [2:0] uvw_pole_pairs;
    logic [1:0] hysteresis;
  } cfg_t;

  typedef struct packed {
    logic [15:0] tx_word;
    logic [2:0]  status;
    logic        finished;
  } result_t;

  function automatic frame_t mk(logic [15:0] word, frame_kind_t kind, logic [2:0] arg,
                                logic last);
    frame_t f;
    f.word = word;
    f.kind = kind;
    f.arg  = arg;
    f.last = last;
    return f;
  endfunction

  // Fixed frame script; out-of-range steps fall back to the first frame
  function automatic frame_t seq_frame(logic [5:0] idx);
    frame_t f;
    case (idx)
      6'd0:  f = mk(16'h0018, FR_CMD,    3'd0,    1'b0);
      6'd1:  f = mk(16'h0000, FR_WDATA,  3'd0,    1'b0);
      6'd2:  f = mk(16'h0019, FR_CMD,    3'd0,    1'b0);
      6'd3:  f = mk(16'h0000, FR_WDATA,  3'd1,    1'b1);
      6'd4:  f = mk(16'h7FFF, FR_CMD,    3'd0,    1'b0);
      6'd5:  f = mk(16'h0000, FR_RANGLE, 3'd0,    1'b1);
      6'd6:  f = mk(16'h0016, FR_CMD,    3'd0,    1'b0);
      6'd7:  f = mk(16'h0000, FR_WDATA,  3'd2,    1'b0);
      6'd8:  f = mk(16'h0017, FR_CMD,    3'd0,    1'b0);
      6'd9:  f = mk(16'h0000, FR_WDATA,  3'd3,    1'b1);
      6'd10: f = mk(16'h4018, FR_CMD,    3'd0,    1'b0);
      6'd11: f = mk(16'h0000, FR_RVER,   3'd0,    1'b0);
      6'd12: f = mk(16'h4019, FR_CMD,    3'd0,    1'b0);
      6'd13: f = mk(16'h0000, FR_RVER,   3'd1,    1'b0);
      6'd14: f = mk(16'h4016, FR_CMD,    3'd0,    1'b0);
      6'd15: f = mk(16'h0000, FR_RVER,   3'd2,    1'b0);
      6'd16: f = mk(16'h4017, FR_CMD,    3'd0,    1'b0);
      6'd17: f = mk(16'h0000, FR_RVER,   3'd3,    1'b1);
      6'd18: f = mk(16'h0003, FR_CMD,    3'd0,    1'b0);
      6'd19: f = mk(16'h0001, FR_WDATA,  ARG_LIT, 1'b0);
      6'd20: f = mk(16'h0003, FR_CMD,    3'd0,    1'b0);
      6'd21: f = mk(16'h0008, FR_WDATA,  ARG_LIT, 1'b1);
      6'd22: f = mk(16'h4003, FR_CMD,    3'd0,    1'b0);
      6'd23: f = mk(16'h0000, FR_RPOLL,  3'd0,    1'b1);
      6'd24: f = mk(16'h0018, FR_CMD,    3'd0,    1'b0);
      6'd25: f = mk(16'h0000, FR_WDATA,  ARG_LIT, 1'b0);
      6'd26: f = mk(16'h0019, FR_CMD,    3'd0,    1'b0);
      6'd27: f = mk(16'h0000, FR_WDATA,  ARG_LIT, 1'b0);
      6'd28: f = mk(16'h0016, FR_CMD,    3'd0,    1'b0);
      6'd29: f = mk(16'h0000, FR_WDATA,  ARG_LIT, 1'b0);
      6'd30: f = mk(16'h0017, FR_CMD,    3'd0,    1'b0);
      6'd31: f = mk(16'h0000, FR_WDATA,  ARG_LIT, 1'b1);
      6'd32: f = mk(16'h0003, FR_CMD,    3'd0,    1'b0);
      6'd33: f = mk(16'h0040, FR_WDATA,  ARG_LIT, 1'b0);
      6'd34: f = mk(16'h0003, FR_CMD,    3'd0,    1'b0);
      6'd35: f = mk(16'h0004, FR_WDATA,  ARG_LIT, 1'b1);
      6'd36: f = mk(16'h4018, FR_CMD,    3'd0,    1'b0);
      6'd37: f = mk(16'h0000, FR_RVER,   3'd0,    1'b0);
      6'd38: f = mk(16'h4019, FR_CMD,    3'd0,    1'b0);
      6'd39: f = mk(16'h0000, FR_RVER,   3'd1,    1'b0);
      6'd40: f = mk(16'h4016, FR_CMD,    3'd0,    1'b0);
      6'd41: f = mk(16'h0000, FR_RVER,   3'd2,    1'b0);
      6'd42: f = mk(16'h4017, FR_CMD,    3'd0,    1'b0);
      6'd43: f = mk(16'h0000, FR_RVER,   3'd3,    1'b1);
      default: f = mk(16'h0018, FR_CMD,  3'd0,    1'b0);
    endcase
    return f;
  endfunction

  // Even parity over bits 0..14 into bit 15
  function automatic logic [15:0] with_parity(logic [15:0] w);
    return {^w[14:0], w[14:0]};
  endfunction

  // SETTINGS1: bit0 fixed 1, bits 1 and 6 fixed 0
  function automatic logic [7:0] settings1(cfg_t c);
    logic [7:0] s;
    s    = 8'h01;
    s[2] = c.direction;
    s[3] = (c.output_mode == OMODE_UVW_PWM);
    s[4] = ~c.daec_enable;
    s[5] = c.abi_res_code[3];
    s[7] = (c.output_mode != OMODE_UVW_ABI);
    return s;
  endfunction

  // SETTINGS2: pole pairs, hysteresis, low resolution bits
  function automatic logic [7:0] settings2(cfg_t c);
    return {c.abi_res_code[2:0], c.hysteresis, c.uvw_pole_pairs};
  endfunction

endpackage

// ----- hw/rtl/encoder_otp_program_sequencer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// encoder_otp_program_sequencer
// Master-side sequencer for programming the OTP settings of a magnetic angle
// encoder over 16-bit SPI frames.
//
// Usage:
//  - cfg_*: register writes (index, data); cfg_ready is always high. Write
//    only while no transaction is in flight.
//  - in_*: a transaction with in_mode 0 starts the sequence and yields the
//    first frame; in_mode 1 carries the answer to the last frame sent
//    (in_rx_word) and yields the next frame on out_tx_word.
//  - out_*: one result per input transaction; out_finished marks the last
//    one, with out_status giving success or the failing group's error.
//  - Path: out_valid rises once the accepted transaction has passed the
//    input register and then the result register.
//  - Throughput: one transaction per cycle while out_stall is low; the step
//    logic between the input register and the result register is combinational.
//  - Stall: while out_stall holds a result, the input register fills and
//    in_stall rises; nothing is dropped.
//  - Reset: clears both pipeline stages, the step index, error and busy
//    state, and loads the register defaults (compensation enabled).
// ---------------------------------------------------------------------------
module encoder_otp_program_sequencer
  import eops_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [15:0] in_rx_word,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_tx_word,
  output logic [2:0]  out_status,
  output logic        out_finished
);

  cfg_t        cfg_r;
  logic        s1_valid_r;
  logic        s1_mode_r;
  logic [15:0] s1_rx_r;
  logic        out_valid_r;
  result_t     out_r;
  result_t     step_res;
  logic        out_free;
  logic        fire;
  logic        in_take;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction      <= 1'b0;
      cfg_r.output_mode    <= 2'd0;
      cfg_r.daec_enable    <= 1'b1;
      cfg_r.abi_res_code   <= 4'd0;
      cfg_r.uvw_pole_pairs <= 3'd0;
      cfg_r.hysteresis     <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DIRECTION:   cfg_r.direction      <= cfg_wdata[0];
        REG_OUTPUT_MODE: cfg_r.output_mode    <= cfg_wdata[1:0];
        REG_DAEC_ENABLE: cfg_r.daec_enable    <= cfg_wdata[0];
        REG_ABI_RES:     cfg_r.abi_res_code   <= cfg_wdata[3:0];
        REG_POLE_PAIRS:  cfg_r.uvw_pole_pairs <= cfg_wdata[2:0];
        REG_HYSTERESIS:  cfg_r.hysteresis     <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r <= in_mode;
      s1_rx_r   <= in_rx_word;
    end
  end

  eops_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .mode    (s1_mode_r),
    .rx_word (s1_rx_r),
    .cfg     (cfg_r),
    .res     (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= step_res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_tx_word  = out_r.tx_word;
  assign out_status   = out_r.status;
  assign out_finished = out_r.finished;

endmodule

// ----- hw/rtl/eops_step.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eops_step
// Sequencer state and the per-transaction step logic: checks the answer to
// the previous frame, updates the step and error state, forms the next frame.
// ---------------------------------------------------------------------------
module eops_step
  import eops_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic        mode,
  input  logic [15:0] rx_word,
  input  cfg_t        cfg,
  output result_t     res
);

  logic [5:0] step_r, step_nxt;
  logic [1:0] ek_r, ek_nxt;
  logic       busy_r, busy_nxt;
  logic [7:0] exp_r   [4];
  logic [7:0] exp_nxt [4];

  frame_t      cur_f, j_f, nxt_f;
  logic        rx_err;
  logic [13:0] rx_data;
  logic [5:0]  j_idx;
  logic [5:0]  nxt_idx;
  logic        poll_again;
  logic        send_frame;
  logic [15:0] nxt_word;

  assign rx_err  = rx_word[14];
  assign rx_data = rx_word[13:0];
  assign cur_f   = seq_frame(step_r);

  // Step logic
  always_comb begin
    step_nxt   = step_r;
    ek_nxt     = ek_r;
    busy_nxt   = busy_r;
    exp_nxt    = exp_r;
    j_idx      = step_r;
    j_f        = cur_f;
    nxt_idx    = step_r;
    poll_again = 1'b0;
    send_frame = 1'b0;
    res        = '0;

    if (!mode) begin
      // start: load settings, restart the script
      exp_nxt[0] = settings1(cfg);
      exp_nxt[1] = settings2(cfg);
      ek_nxt     = ERR_NONE;
      busy_nxt   = 1'b1;
      nxt_idx    = '0;
      step_nxt   = '0;
      send_frame = 1'b1;
    end else if (busy_r) begin
      // check the answer to the frame last sent
      case (cur_f.kind)
        FR_CMD: begin
          if (rx_err) begin
            ek_nxt = cur_f.word[14] ? ERR_READ : ERR_WRITE;
            j_idx  = step_r + 6'd1;
          end
        end
        FR_WDATA: begin
          if (rx_err) ek_nxt = ERR_WRITE;
        end
        FR_RANGLE: begin
          if (rx_err) begin
            ek_nxt = ERR_READ;
          end else begin
            exp_nxt[2] = rx_data[13:6];
            exp_nxt[3] = {2'b11, rx_data[5:0]};
          end
        end
        FR_RVER: begin
          if (rx_err) begin
            ek_nxt = ERR_READ;
          end else if (rx_data[7:0] != exp_r[cur_f.arg[1:0]] && ek_r == ERR_NONE) begin
            ek_nxt = ERR_VERIFY;
          end
        end
        FR_RPOLL: begin
          if (rx_err) ek_nxt = ERR_READ;
          else        poll_again = (rx_data != PROG_DONE);
        end
        default: ;
      endcase
      j_f = seq_frame(j_idx);

      // choose the next frame or end the sequence
      if (cur_f.kind == FR_CMD && !rx_err) begin
        nxt_idx = step_r + 6'd1;
      end else if (poll_again) begin
        nxt_idx = POLL_STEP;
      end else begin
        nxt_idx = j_idx + 6'd1;
      end

      if (!(cur_f.kind == FR_CMD && !rx_err) && !poll_again && j_f.last
          && (ek_nxt != ERR_NONE || j_idx == LAST_STEP)) begin
        res.tx_word  = '0;
        res.status   = (ek_nxt != ERR_NONE) ? ({1'b0, ek_nxt} + 3'd1) : STAT_SUCCESS;
        res.finished = 1'b1;
        busy_nxt     = 1'b0;
        step_nxt     = '0;
      end else begin
        if (nxt_idx > LAST_STEP) nxt_idx = '0;
        step_nxt   = nxt_idx;
        send_frame = 1'b1;
        res.status = STAT_RUNNING;
      end
    end

    // Word for the next frame: stored data word or script literal
    nxt_f    = seq_frame(nxt_idx);
    nxt_word = nxt_f.word;
    if (nxt_f.kind == FR_WDATA && !nxt_f.arg[2]) begin
      nxt_word = {8'h00, exp_nxt[nxt_f.arg[1:0]]};
    end
    if (send_frame) res.tx_word = with_parity(nxt_word);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      ek_r   <= ERR_NONE;
      busy_r <= 1'b0;
    end else if (fire) begin
      step_r <= step_nxt;
      ek_r   <= ek_nxt;
      busy_r <= busy_nxt;
    end
  end

  // Expected words, written before first use
  always_ff @(posedge clk) begin
    if (fire) begin
      exp_r <= exp_nxt;
    end
  end

endmodule
